### design/erase_count_histogram_macros.svh
// Assertion macros shared by the erase counter histogram RTL.
// Define ASSERT_OFF to compile the checks away; no other dependencies.
`ifndef ERASE_COUNT_HISTOGRAM_MACROS_SVH
`define ERASE_COUNT_HISTOGRAM_MACROS_SVH

`ifndef ASSERT_OFF
// antecedent true -> consequent true in the same cycle
`define ECH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("histogram assertion failed");
// antecedent true -> consequent true in the next cycle
`define ECH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("histogram assertion failed");
`else
`define ECH_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ECH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### design/ech_pkg.sv
// Shared types and constants for the erase counter histogram.
// Used by ech_div, erase_count_histogram and tb_top; no dependencies.
package ech_pkg;

  localparam int NUM_BINS_DEF = 6;
  localparam int NUM_THR      = 5;
  localparam int VAL_W        = 31;
  localparam int CNT_W        = 32;
  localparam int SUM_W        = 64;
  localparam int DIV_STEPS    = 64;
  localparam int STEP_W       = $clog2(DIV_STEPS);

  localparam logic [2:0] CFG_BINS_IN_USE     = 3'd0;
  localparam logic [2:0] CFG_THRESHOLD_ONE   = 3'd1;
  localparam logic [2:0] CFG_THRESHOLD_TWO   = 3'd2;
  localparam logic [2:0] CFG_THRESHOLD_THREE = 3'd3;
  localparam logic [2:0] CFG_THRESHOLD_FOUR  = 3'd4;
  localparam logic [2:0] CFG_THRESHOLD_FIVE  = 3'd5;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] BINS_RESET = 3'd6;
  localparam logic [VAL_W-1:0] THR_RESET [NUM_THR] = '{
    31'd10, 31'd100, 31'd1000, 31'd10000, 31'd100000
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_UPD_TOT,
    S_UPD_BIN,
    S_RD_START,
    S_RD_DIV,
    S_RD_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### design/erase_count_histogram.sv
// Erase counter histogram: binned count/sum/min/max plus overall totals.
// Add item: a skipped marker returns straight to idle; otherwise a threshold search
//   reuses a single comparator one bin per cycle, then totals and bin are updated.
// Read item: runs the 64-step mean divider, skipped for an empty bin. Clear item:
// done on acceptance. Stats and registers take their reset values on rst.
module erase_count_histogram #(
  parameter int NUM_BINS = ech_pkg::NUM_BINS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [ech_pkg::VAL_W-1:0] cfg_data,
  // input items
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                opcode,
  input  logic [31:0]               count_value,
  input  logic [2:0]                bin_select,
  // result items
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ech_pkg::VAL_W-1:0] bin_low,
  output logic [ech_pkg::CNT_W-1:0] bin_count,
  output logic [ech_pkg::VAL_W-1:0] bin_min,
  output logic [ech_pkg::VAL_W-1:0] bin_mean,
  output logic [ech_pkg::VAL_W-1:0] bin_max,
  output logic [ech_pkg::CNT_W-1:0] total_count,
  output logic [ech_pkg::VAL_W-1:0] total_min,
  output logic [ech_pkg::VAL_W-1:0] total_max
);
  import ech_pkg::*;

`include "erase_count_histogram_macros.svh"

  localparam int BIN_W = $clog2(NUM_BINS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [2:0]       bins_in_use;
  logic [VAL_W-1:0] thr [NUM_THR];

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_in_use <= BINS_RESET;
      thr         <= THR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BINS_IN_USE:     bins_in_use <= cfg_data[2:0];
        CFG_THRESHOLD_ONE:   thr[0]      <= cfg_data;
        CFG_THRESHOLD_TWO:   thr[1]      <= cfg_data;
        CFG_THRESHOLD_THREE: thr[2]      <= cfg_data;
        CFG_THRESHOLD_FOUR:  thr[3]      <= cfg_data;
        CFG_THRESHOLD_FIVE:  thr[4]      <= cfg_data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // Active bin count, clamped to 1..NUM_BINS.
  logic [2:0] active;
  always_comb begin
    if (bins_in_use == 3'd0)              active = 3'd1;
    else if (bins_in_use > 3'(NUM_BINS))  active = 3'(NUM_BINS);
    else                                  active = bins_in_use;
  end

  // ---------------------------------------------------------------------------
  // Statistics stores (small, flop based)
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] bin_counts   [NUM_BINS];
  logic [SUM_W-1:0] bin_sums     [NUM_BINS];
  logic [VAL_W-1:0] bin_minimums [NUM_BINS];
  logic [VAL_W-1:0] bin_maximums [NUM_BINS];
  logic [VAL_W-1:0] overall_min;
  logic [VAL_W-1:0] overall_max;
  logic [CNT_W-1:0] overall_count;

  // ---------------------------------------------------------------------------
  // Sequencer state and item latches
  // ---------------------------------------------------------------------------
  state_t           state;
  state_t           state_next;
  logic [VAL_W-1:0] smp;      // sample under way
  logic [BIN_W-1:0] bin;      // bin found by the threshold walk
  logic [2:0]       rd_sel;   // bin being read

  logic in_acc;
  logic do_clear;
  logic step_bin;
  logic div_start;
  logic out_load;

  // shared threshold comparator: one threshold per search cycle
  logic [VAL_W-1:0] thr_cur;
  logic             go_on;
  always_comb begin
    thr_cur = '0;
    if (3'(bin) < 3'(NUM_THR)) thr_cur = thr[3'(bin)];
    go_on = (4'(bin) + 4'd1 < 4'(active)) && (smp >= thr_cur);
  end

  // read path: select the addressed bin
  logic [BIN_W-1:0] rsel;
  logic             sel_ok;
  logic             rd_nz;
  logic [VAL_W-1:0] rd_low;
  assign rsel   = rd_sel[BIN_W-1:0];
  assign sel_ok = rd_sel < 3'(NUM_BINS);
  assign rd_nz  = sel_ok && (bin_counts[rsel] != '0);

  always_comb begin
    rd_low = '0;
    if (sel_ok && rd_sel != 3'd0) rd_low = thr[3'(rd_sel - 3'd1)];
  end

  // mean divider
  logic [VAL_W-1:0] div_q;
  div_status_t      div_stat;

  ech_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (bin_sums[rsel]),
    .divisor  (bin_counts[rsel]),
    .quotient (div_q),
    .status   (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_stall   = (state != S_IDLE);
    in_acc     = in_valid && (state == S_IDLE);
    do_clear   = 1'b0;
    step_bin   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (opcode)
            OP_ADD: begin
              // markers and oversized words never reach the stores
              if (count_value < {1'b0, {VAL_W{1'b1}}}) state_next = S_SEARCH;
            end
            OP_READ:  state_next = S_RD_START;
            OP_CLEAR: do_clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        if (go_on) step_bin = 1'b1;
        else       state_next = S_UPD_TOT;
      end
      S_UPD_TOT: state_next = S_UPD_BIN;
      S_UPD_BIN: state_next = S_IDLE;
      S_RD_START: begin
        if (rd_nz) begin
          div_start  = 1'b1;
          state_next = S_RD_DIV;
        end else begin
          state_next = S_RD_DONE;
        end
      end
      S_RD_DIV: begin
        if (div_stat.done) state_next = S_RD_DONE;
      end
      S_RD_DONE: begin
        // output register free or being emptied this cycle
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp    <= count_value[VAL_W-1:0];
      rd_sel <= bin_select;
      bin    <= '0;
    end else if (step_bin) begin
      bin <= bin + BIN_W'(1);
    end
  end

  // store updates: totals and the bin are done in separate cycles
  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      for (int k = 0; k < NUM_BINS; k++) begin
        bin_counts[k]   <= '0;
        bin_sums[k]     <= '0;
        bin_minimums[k] <= '1;
        bin_maximums[k] <= '0;
      end
      overall_min   <= '1;
      overall_max   <= '0;
      overall_count <= '0;
    end else if (state == S_UPD_TOT) begin
      if (overall_count != '1) overall_count <= overall_count + CNT_W'(1);
      if (smp < overall_min)   overall_min   <= smp;
      if (smp > overall_max)   overall_max   <= smp;
    end else if (state == S_UPD_BIN) begin
      // a saturated bin still tracks min and max
      if (bin_counts[bin] != '1) begin
        bin_counts[bin] <= bin_counts[bin] + CNT_W'(1);
        bin_sums[bin]   <= bin_sums[bin] + SUM_W'(smp);
      end
      if (smp < bin_minimums[bin]) bin_minimums[bin] <= smp;
      if (smp > bin_maximums[bin]) bin_maximums[bin] <= smp;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst)             out_valid <= 1'b0;
    else if (out_load)   out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      bin_low     <= rd_low;
      bin_count   <= sel_ok ? bin_counts[rsel] : '0;
      bin_min     <= rd_nz ? bin_minimums[rsel] : '0;
      bin_mean    <= rd_nz ? div_q : '0;
      bin_max     <= sel_ok ? bin_maximums[rsel] : '0;
      total_count <= overall_count;
      total_min   <= (overall_count != '0) ? overall_min : '0;
      total_max   <= overall_max;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ECH_ASSERT_IMPLY(a_div_done_waits, clk, rst, div_stat.done, state == S_RD_DIV)
  `ECH_ASSERT_IMPLY(a_div_busy_in_read, clk, rst, div_stat.busy, state == S_RD_DIV)
  `ECH_ASSERT_IMPLY(a_empty_max, clk, rst, overall_count == '0, overall_max == '0)
  `ECH_ASSERT_NEXT(a_read_busy, clk, rst, in_acc && opcode == OP_READ, state == S_RD_START)
  `ECH_ASSERT_IMPLY(a_result_from_read, clk, rst, $rose(out_valid), $past(state) == S_RD_DONE)

endmodule

### design/ech_div.sv
// Restoring divider, one quotient bit per cycle, for the bin mean.
// Depends on ech_pkg.
module ech_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [ech_pkg::SUM_W-1:0]         dividend,
  input  logic [ech_pkg::CNT_W-1:0]         divisor,
  output logic [ech_pkg::VAL_W-1:0]         quotient,
  output ech_pkg::div_status_t              status
);
  import ech_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  acc;   // dividend bits shift out, quotient bits shift in
  logic [CNT_W-1:0]  rem;

  logic [CNT_W:0]    rem_shift;
  logic [CNT_W:0]    rem_diff;
  logic              qbit;
  logic [CNT_W-1:0]  rem_next;

  always_comb begin
    rem_shift = {rem, acc[SUM_W-1]};
    rem_diff  = rem_shift - {1'b0, divisor};
    qbit      = rem_shift >= {1'b0, divisor};
    rem_next  = qbit ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= dividend;
      rem  <= '0;
      step <= '0;
    end else if (busy) begin
      acc  <= {acc[SUM_W-2:0], qbit};
      rem  <= rem_next;
      step <= step + STEP_W'(1);
    end
  end

  // mean never exceeds the largest sample, so the low bits hold it all
  assign quotient    = acc[VAL_W-1:0];
  assign status.busy = busy;
  assign status.done = done;

endmodule

### bench/tb_top.sv
// Self-checking bench for erase_count_histogram: a directed table, then random
// traffic under several bin/threshold settings, checked by an in-bench predictor.
// Depends on ech_pkg and the erase_count_histogram RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ech_pkg::*;

  localparam int          NBINS             = NUM_BINS_DEF;
  localparam int unsigned LIMIT_CYCLES      = 1_000_000;
  localparam int          ITEMS_PER_SETTING = 220;
  localparam int          DRAIN_CYCLES      = 100;
  localparam int          NUM_SETTINGS      = 7;
  localparam logic [31:0] LIM31             = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT32             = 32'hFFFF_FFFF;
  localparam logic [1:0]  OP_UNUSED         = 2'd3;
  localparam logic [2:0]  THR_REG [NUM_THR] = '{CFG_THRESHOLD_ONE, CFG_THRESHOLD_TWO,
                                                CFG_THRESHOLD_THREE, CFG_THRESHOLD_FOUR,
                                                CFG_THRESHOLD_FIVE};

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // One bin report, same field order as the result ports.
  typedef struct packed {
    val_t bin_low;
    cnt_t bin_count;
    val_t bin_min;
    val_t bin_mean;
    val_t bin_max;
    cnt_t total_count;
    val_t total_min;
    val_t total_max;
  } bin_report_t;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] value;
    logic [2:0]  sel;
    bit          typed;   // report below is typed in, not predicted
    bin_report_t report;
  } stim_row_t;

  // Output-side flow control patterns.
  typedef enum int {FLOW_FREE, FLOW_COIN, FLOW_PERIODIC, FLOW_HEAVY} sink_mode_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_write   = 1'b0;
  logic [2:0]  cfg_index   = CFG_BINS_IN_USE;
  val_t        cfg_data    = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode      = OP_ADD;
  logic [31:0] count_value = '0;
  logic [2:0]  bin_select  = '0;
  logic        out_valid;
  logic        out_stall   = 1'b1;
  val_t        bin_low;
  cnt_t        bin_count;
  val_t        bin_min;
  val_t        bin_mean;
  val_t        bin_max;
  cnt_t        total_count;
  val_t        total_min;
  val_t        total_max;

  erase_count_histogram uut (
    .clk, .rst,
    .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .opcode, .count_value, .bin_select,
    .out_valid, .out_stall,
    .bin_low, .bin_count, .bin_min, .bin_mean, .bin_max,
    .total_count, .total_min, .total_max
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Histogram predictor: own copy of the registers and statistics stores.
  // ---------------------------------------------------------------------------
  logic [2:0]  pred_bins;
  val_t        pred_thr [NUM_THR];
  cnt_t        hist_count [NBINS];
  logic [63:0] hist_sum [NBINS];
  val_t        hist_min [NBINS];
  val_t        hist_max [NBINS];
  val_t        all_min;
  val_t        all_max;
  cnt_t        all_count;

  bin_report_t pending_reports [$];   // reads accepted, report not yet seen
  bin_report_t oldest_report;

  int unsigned items_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatches     = 0;
  int unsigned settings_done  = 0;
  int unsigned cycles         = 0;
  int          burst_left     = 0;

  function automatic void clear_histogram();
    for (int k = 0; k < NBINS; k++) begin
      hist_count[k] = '0;
      hist_sum[k]   = '0;
      hist_min[k]   = '1;
      hist_max[k]   = '0;
    end
    all_min   = '1;
    all_max   = '0;
    all_count = '0;
  endfunction

  // Bin = number of leading thresholds reached, capped by the active bin count
  // (0 acts as 1, anything past NBINS acts as NBINS). No ordering check.
  function automatic int bin_of(val_t v);
    int active;
    int b;
    active = (pred_bins == 0) ? 1 : (pred_bins > NBINS) ? NBINS : int'(pred_bins);
    b = 0;
    while (b + 1 < active && b < NUM_THR && v >= pred_thr[b])
      b++;
    return b;
  endfunction

  function automatic void record_counter(logic [31:0] raw);
    val_t v;
    int   b;
    // markers (0x7FFFFFFF, 0xFFFFFFFC..F) and anything past 31 bits are dropped
    if (raw >= LIM31)
      return;
    v = raw[VAL_W-1:0];
    b = bin_of(v);
    if (all_count != SAT32)
      all_count++;
    if (v < all_min)
      all_min = v;
    if (v > all_max)
      all_max = v;
    // a saturated bin keeps tracking min/max but freezes count and sum
    if (hist_count[b] != SAT32) begin
      hist_count[b]++;
      hist_sum[b] += 64'(v);
    end
    if (v < hist_min[b])
      hist_min[b] = v;
    if (v > hist_max[b])
      hist_max[b] = v;
  endfunction

  function automatic bin_report_t report_bin(logic [2:0] sel);
    bin_report_t r;
    cnt_t        c;
    r = '0;
    // select past the last bin reports only the totals
    if (sel < NBINS) begin
      c           = hist_count[sel];
      r.bin_low   = (sel == 0) ? '0 : pred_thr[sel - 1];
      r.bin_count = c;
      if (c != 0) begin
        r.bin_min  = hist_min[sel];
        r.bin_mean = val_t'(hist_sum[sel] / c);
      end
      r.bin_max = hist_max[sel];
    end
    r.total_count = all_count;
    r.total_min   = (all_count != 0) ? all_min : '0;
    r.total_max   = all_max;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Present one item and hold it until accepted, then update the predictor.
  task automatic send_item(logic [1:0] op, logic [31:0] value, logic [2:0] sel,
                           bit typed, bin_report_t typed_report);
    in_valid    <= 1'b1;
    opcode      <= op;
    count_value <= value;
    bin_select  <= sel;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    items_accepted++;
    case (op)
      OP_ADD:   record_counter(value);
      OP_CLEAR: clear_histogram();
      OP_READ:  pending_reports.push_back(typed ? typed_report : report_bin(sel));
      default:  ;  // unused opcode: dropped, no report
    endcase
  endtask

  // Bursts of random length, usually separated by a short gap.
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Quiet point for register writes: no report pending and any trailing add
  // (which gives no report) has had time to finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_setting(logic [2:0] active_bins, val_t thr [NUM_THR]);
    cfg_write <= 1'b1;
    cfg_index <= CFG_BINS_IN_USE;
    cfg_data  <= val_t'(active_bins);
    @(posedge clk);
    pred_bins = active_bins;
    for (int k = 0; k < NUM_THR; k++) begin
      cfg_index <= THR_REG[k];
      cfg_data  <= thr[k];
      @(posedge clk);
      pred_thr[k] = thr[k];
    end
    cfg_write <= 1'b0;
    settings_done++;
  endtask

  // Random traffic. Counters are biased around the live thresholds so that
  // bin edges get hit; markers, oversized words and the extremes mixed in.
  task automatic run_random(int n);
    int          done_items;
    int          pick;
    logic [1:0]  op;
    logic [31:0] value;
    logic [2:0]  sel;
    done_items = 0;
    while (done_items < n) begin
      pick = $urandom_range(0, 99);
      op = (pick < 68) ? OP_ADD : (pick < 92) ? OP_READ : (pick < 95) ? OP_CLEAR : OP_UNUSED;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        value = 32'(pred_thr[$urandom_range(0, NUM_THR - 1)]) + $urandom_range(0, 4);
        value = (value >= 2) ? value - 2 : 32'd0;
      end else if (pick < 62) begin
        value = $urandom_range(0, 200000);
      end else if (pick < 77) begin
        value = $urandom & LIM31;
      end else if (pick < 87) begin
        value = ($urandom_range(0, 4) == 0) ? LIM31 : SAT32 - $urandom_range(0, 3);
      end else if (pick < 92) begin
        value = ($urandom_range(0, 1) == 0) ? 32'd0 : LIM31 - 1;
      end else begin
        value = $urandom;
      end
      sel = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                        : 3'($urandom_range(0, NBINS - 1));
      // every item offered, dropped ones too, counts toward the phase length
      done_items++;
      pace_sender();
      send_item(op, value, sel, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: checker plus stall pattern, including two long hold-offs
  // that back the block up into its input while the sender keeps offering.
  // ---------------------------------------------------------------------------
  sink_mode_t sink_mode  = FLOW_FREE;
  int         mode_left  = 0;
  int         hold_left  = 0;
  int         holds_done = 0;

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0d, actual %0d", name, want, seen);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_reports.size() == 0) begin
        $error("bin report with no read waiting");
        mismatches++;
      end else begin
        oldest_report = pending_reports.pop_front();
        check_field("bin_low",     32'(oldest_report.bin_low),   32'(bin_low));
        check_field("bin_count",   oldest_report.bin_count,      bin_count);
        check_field("bin_min",     32'(oldest_report.bin_min),   32'(bin_min));
        check_field("bin_mean",    32'(oldest_report.bin_mean),  32'(bin_mean));
        check_field("bin_max",     32'(oldest_report.bin_max),   32'(bin_max));
        check_field("total_count", oldest_report.total_count,    total_count);
        check_field("total_min",   32'(oldest_report.total_min), 32'(total_min));
        check_field("total_max",   32'(oldest_report.total_max), 32'(total_max));
      end
    end
    if (hold_left == 0 && holds_done < 2 && results_seen >= (holds_done == 0 ? 40 : 300)) begin
      hold_left = 400;
      holds_done++;
    end
    if (mode_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(50, 300);
    end
    mode_left--;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      case (sink_mode)
        FLOW_FREE:     out_stall <= 1'b0;
        FLOW_COIN:     out_stall <= ($urandom_range(0, 1) == 0);
        FLOW_PERIODIC: out_stall <= ((mode_left % 5) < 2);
        default:       out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  stim_row_t directed [$];

  function automatic void add_row(logic [1:0] op, logic [31:0] value, logic [2:0] sel,
                                  bit typed = 1'b0, bin_report_t report = '0);
    stim_row_t row;
    row.op     = op;
    row.value  = value;
    row.sel    = sel;
    row.typed  = typed;
    row.report = report;
    directed.push_back(row);
  endfunction

  initial begin
    bin_report_t r;
    logic [2:0]  active_bins;
    val_t        thr [NUM_THR];

    pred_bins = BINS_RESET;
    pred_thr  = THR_RESET;
    clear_histogram();

    // Directed table, reset thresholds 10/100/1000/10000/100000.
    add_row(OP_READ, 32'd0, 3'd0, 1'b1, '0);            // empty bin after reset
    add_row(OP_READ, 32'd0, 3'd7, 1'b1, '0);            // select past last bin
    add_row(OP_ADD, 32'd0, 3'd0);                       // smallest counter
    add_row(OP_ADD, LIM31 - 1, 3'd0);                   // largest counter
    add_row(OP_ADD, LIM31, 3'd0);                       // marker
    add_row(OP_ADD, 32'hFFFF_FFFC, 3'd0);               // marker range
    add_row(OP_ADD, 32'hFFFF_FFFD, 3'd0);
    add_row(OP_ADD, 32'hFFFF_FFFE, 3'd0);
    add_row(OP_ADD, SAT32, 3'd0);
    add_row(OP_ADD, 32'h8000_0000, 3'd0);               // oversized, dropped
    add_row(OP_ADD, 32'hFFFF_FFFB, 3'd0);
    add_row(OP_UNUSED, 32'd5, 3'd5);                    // unused opcode
    add_row(OP_ADD, 32'd9, 3'd0);                       // either side of edges
    add_row(OP_ADD, 32'd10, 3'd0);
    add_row(OP_ADD, 32'd99, 3'd0);
    add_row(OP_ADD, 32'd100, 3'd0);
    add_row(OP_ADD, 32'd99999, 3'd0);
    add_row(OP_ADD, 32'd100000, 3'd0);
    // bin 0 holds 0 and 9; eight valid counters overall
    r = '0;
    r.bin_count   = 32'd2;
    r.bin_mean    = 31'd4;
    r.bin_max     = 31'd9;
    r.total_count = 32'd8;
    r.total_max   = val_t'(LIM31 - 1);
    add_row(OP_READ, 32'd0, 3'd0, 1'b1, r);
    add_row(OP_READ, 32'hFFFF_FFFF, 3'd5);
    add_row(OP_READ, 32'd0, 3'd1);
    add_row(OP_READ, 32'd0, 3'd4);
    add_row(OP_READ, 32'd0, 3'd6);
    add_row(OP_CLEAR, 32'd0, 3'd0);
    r = '0;
    r.bin_low = 31'd100000;                             // cleared top bin
    add_row(OP_READ, 32'd0, 3'd5, 1'b1, r);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      pace_sender();
      send_item(directed[i].op, directed[i].value, directed[i].sel,
                directed[i].typed, directed[i].report);
    end
    run_random(ITEMS_PER_SETTING);

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      case (p)
        0: begin  // one bin: everything lands in bin 0
          active_bins = 3'd1;
          thr  = '{31'd5, 31'd50, 31'd500, 31'd5000, 31'd50000};
        end
        1: begin  // zero active bins acts as one
          active_bins = 3'd0;
          thr  = '{31'd10, 31'd20, 31'd30, 31'd40, 31'd50};
        end
        2: begin  // over-range bin count, lowest thresholds
          active_bins = 3'd7;
          thr  = '{31'd1, 31'd2, 31'd3, 31'd4, 31'd5};
        end
        3: begin  // widest spread up to the top threshold
          active_bins = 3'd6;
          thr  = '{31'd1000, 31'd1000000, 31'd100000000, 31'd1000000000, 31'd2147483646};
        end
        4: begin  // unordered thresholds
          active_bins = 3'd3;
          thr  = '{31'd500, 31'd50, 31'd5000, 31'd20, 31'd100000};
        end
        5: begin  // random ascending thresholds
          active_bins = 3'd4;
          thr[0] = val_t'($urandom_range(1, 500));
          for (int k = 1; k < NUM_THR; k++)
            thr[k] = thr[k - 1] + val_t'($urandom_range(1, 300000));
        end
        default: begin  // only the largest counter reaches bin 1
          active_bins = 3'd2;
          thr  = '{31'd2147483646, 31'd2147483646, 31'd2147483646,
                   31'd2147483646, 31'd2147483646};
        end
      endcase
      wait_idle();
      load_setting(active_bins, thr);
      run_random(ITEMS_PER_SETTING);
    end

    wait_idle();
    $display("Covered %0d items and %0d bin reports over %0d register settings,",
             items_accepted, results_seen, settings_done + 1);
    $display("with bursty input, patterned output stalls and %0d long hold-offs.",
             holds_done);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
